// ----- rtl/dcnt_pkg.sv -----
// Shared types, constants and helpers for the decaying counter.
package dcnt_pkg;

	localparam int VAL_W     = 48;
	localparam int CMD_W     = 2;
	localparam int COUNT_W   = 16;
	localparam int UNIT_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int DIV_W     = 32;
	localparam int MAG_W     = VAL_W + 1;

	localparam logic [CMD_W-1:0] CMD_INC  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DEC  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

	localparam logic [UNIT_W-1:0] UNIT_MS  = 2'd0;
	localparam logic [UNIT_W-1:0] UNIT_SEC = 2'd1;
	localparam logic [UNIT_W-1:0] UNIT_MIN = 2'd2;
	localparam logic [UNIT_W-1:0] UNIT_BAD = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_RATE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UNIT  = 2'd2;

	localparam logic [VAL_W-1:0] VAL_MAX   = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] VAL_MIN   = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic [MAG_W-1:0] DEG_LIMIT = {1'b1, {VAL_W{1'b0}}};

	typedef struct packed {
		logic [CMD_W-1:0]        cmd;
		logic signed [VAL_W-1:0] amount;
		logic [VAL_W-1:0]        now_ms;
	} req_t;

	typedef struct packed {
		logic                    status;
		logic signed [VAL_W-1:0] result_value;
	} rsp_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] decay_step;
		logic [COUNT_W-1:0]      interval_count;
		logic [UNIT_W-1:0]       interval_unit;
	} cfg_t;

	// milliseconds per time unit
	function automatic logic [15:0] unit_ms(input logic [UNIT_W-1:0] unit);
		logic [15:0] ms;
		case (unit)
			UNIT_MS:  ms = 16'd1;
			UNIT_SEC: ms = 16'd1000;
			UNIT_MIN: ms = 16'd60000;
			default:  ms = 16'd1;
		endcase
		return ms;
	endfunction

endpackage

// ----- rtl/dcnt_alu.sv -----
// Shared add/subtract unit used by the arithmetic steps of the sequencer.
module dcnt_alu #(
	parameter int AW = 52
) (
	input  logic [AW-1:0] a,
	input  logic [AW-1:0] b,
	input  logic          sub,
	output logic [AW-1:0] sum
);
	assign sum = a + (sub ? ~b : b) + AW'(sub);
endmodule

// ----- rtl/dcnt_cfg.sv -----
// Configuration register file.
module dcnt_cfg #(
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dcnt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dcnt_pkg::VAL_W-1:0]     cfg_data,
	output dcnt_pkg::cfg_t                 regs
);
	import dcnt_pkg::*;

	localparam logic [VAL_W-1:0] RATE_RST = VAL_W'(1) << FRAC_BITS;

	cfg_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.decay_step     <= RATE_RST;
			regs_q.interval_count <= COUNT_W'(1);
			regs_q.interval_unit  <= UNIT_MS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RATE:  regs_q.decay_step     <= cfg_data;
				REG_COUNT: regs_q.interval_count <= cfg_data[COUNT_W-1:0];
				REG_UNIT:  regs_q.interval_unit  <= cfg_data[UNIT_W-1:0];
				default: begin
				end
			endcase
		end
	end
endmodule

// ----- rtl/dcnt_core.sv -----
// Counter state and command sequencer around the shared add/subtract unit.
module dcnt_core #(
	parameter int TIME_WIDTH = 48
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  dcnt_pkg::req_t req,
	output logic           req_stall,
	input  dcnt_pkg::cfg_t regs,
	input  logic           slot_free,
	output logic           done,
	output dcnt_pkg::rsp_t rsp_d
);
	import dcnt_pkg::*;

	localparam int TW = TIME_WIDTH;
	localparam int AW = ((TW > 50) ? TW : 50) + 2;
	localparam int CW = $clog2(TW);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DISP   = 4'd1;
	localparam logic [3:0] S_SUBAMT = 4'd2;
	localparam logic [3:0] S_AGE    = 4'd3;
	localparam logic [3:0] S_DIV    = 4'd4;
	localparam logic [3:0] S_ABS    = 4'd5;
	localparam logic [3:0] S_MUL    = 4'd6;
	localparam logic [3:0] S_APPLY  = 4'd7;
	localparam logic [3:0] S_ADDAMT = 4'd8;
	localparam logic [3:0] S_REPLY  = 4'd9;

	logic [3:0]       state_q;
	logic [CMD_W-1:0] cmd_q;
	logic [VAL_W-1:0] amt_q;
	logic [TW-1:0]    now_q;
	logic             exists_q;
	logic [VAL_W-1:0] raw_q;
	logic [TW-1:0]    created_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] div_q;
	logic [TW-1:0]    q_q;
	logic [VAL_W-1:0] rabs_q;
	logic [MAG_W-1:0] acc_q;
	logic [CW-1:0]    cnt_q;
	logic             pass_q;
	logic             status_q;
	logic [VAL_W-1:0] res_q;

	logic [AW-1:0]    alu_a, alu_b, sum;
	logic             alu_sub;
	logic             neg, hi, all1;
	logic [VAL_W-1:0] clamp0, clamp_full, deg;
	logic [MAG_W-1:0] acc_next;
	logic [63:0]      now_wide;
	logic [COUNT_W-1:0] cnt_eff;

	function automatic logic [AW-1:0] sx(input logic [VAL_W-1:0] x);
		return {{(AW-VAL_W){x[VAL_W-1]}}, x};
	endfunction

	dcnt_alu #(.AW(AW)) u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.sum (sum)
	);

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			S_SUBAMT: begin
				alu_a   = sx(raw_q);
				alu_b   = sx(amt_q);
				alu_sub = 1'b1;
			end
			S_AGE: begin
				alu_a   = AW'(now_q);
				alu_b   = AW'(created_q);
				alu_sub = 1'b1;
			end
			S_DIV: begin
				alu_a   = AW'({rem_q, q_q[TW-1]});
				alu_b   = AW'(div_q);
				alu_sub = 1'b1;
			end
			S_ABS: begin
				alu_b   = sx(regs.decay_step);
				alu_sub = regs.decay_step[VAL_W-1];
			end
			S_MUL: begin
				alu_a = AW'({acc_q, 1'b0});
				alu_b = q_q[TW-1] ? AW'(rabs_q) : '0;
			end
			S_APPLY: begin
				alu_a   = sx(raw_q);
				alu_b   = AW'(acc_q);
				alu_sub = !regs.decay_step[VAL_W-1];
			end
			S_ADDAMT: begin
				alu_a = sx(raw_q);
				alu_b = sx(amt_q);
			end
			default: begin
			end
		endcase
	end

	// saturation of the unit's result
	always_comb begin
		neg        = sum[AW-1];
		hi         = |sum[AW-2:VAL_W-1];
		all1       = &sum[AW-2:VAL_W-1];
		clamp0     = neg ? '0 : (hi ? VAL_MAX : sum[VAL_W-1:0]);
		clamp_full = neg ? (all1 ? sum[VAL_W-1:0] : VAL_MIN)
		                 : (hi ? VAL_MAX : sum[VAL_W-1:0]);
		deg        = (regs.interval_unit == UNIT_BAD) ? '0 : clamp0;
		acc_next   = ((|sum[AW-1:MAG_W]) || (sum[MAG_W-1] && (|sum[MAG_W-2:0])))
		             ? DEG_LIMIT : sum[MAG_W-1:0];
		now_wide   = 64'(req.now_ms);
		cnt_eff    = (regs.interval_count == '0) ? COUNT_W'(1) : regs.interval_count;
	end

	assign req_stall = (state_q != S_IDLE);
	assign done      = (state_q == S_REPLY) && slot_free;
	assign rsp_d     = '{status: status_q, result_value: res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			exists_q  <= 1'b0;
			raw_q     <= '0;
			created_q <= '0;
			pass_q    <= 1'b0;
			cnt_q     <= '0;
			acc_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						cmd_q   <= req.cmd;
						amt_q   <= req.amount;
						now_q   <= now_wide[TW-1:0];
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					status_q <= 1'b1;
					res_q    <= '0;
					pass_q   <= 1'b0;
					state_q  <= S_REPLY;
					case (cmd_q)
						CMD_INC: begin
							if (!exists_q) begin
								exists_q  <= 1'b1;
								raw_q     <= amt_q;
								created_q <= now_q;
								res_q     <= amt_q;
								status_q  <= 1'b0;
							end else begin
								state_q <= S_AGE;
							end
						end
						CMD_DEC:  if (exists_q) state_q <= S_SUBAMT;
						CMD_PEEK: if (exists_q) state_q <= S_AGE;
						default: begin
						end
					endcase
				end
				S_SUBAMT: begin
					if (clamp0 == '0) begin
						exists_q <= 1'b0;
						status_q <= 1'b0;
						res_q    <= '0;
						state_q  <= S_REPLY;
					end else begin
						raw_q   <= clamp0;
						state_q <= S_AGE;
					end
				end
				S_AGE: begin
					q_q     <= neg ? '0 : sum[TW-1:0];
					rem_q   <= '0;
					div_q   <= DIV_W'(unit_ms(regs.interval_unit)) * DIV_W'(cnt_eff);
					cnt_q   <= CW'(TW - 1);
					state_q <= (regs.interval_unit == UNIT_BAD) ? S_APPLY : S_DIV;
				end
				S_DIV: begin
					rem_q <= neg ? {rem_q[DIV_W-2:0], q_q[TW-1]} : sum[DIV_W-1:0];
					q_q   <= {q_q[TW-2:0], !neg};
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == '0) state_q <= S_ABS;
				end
				S_ABS: begin
					rabs_q  <= sum[VAL_W-1:0];
					acc_q   <= '0;
					cnt_q   <= CW'(TW - 1);
					state_q <= S_MUL;
				end
				S_MUL: begin
					acc_q <= acc_next;
					q_q   <= {q_q[TW-2:0], 1'b0};
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == '0) state_q <= S_APPLY;
				end
				S_APPLY: begin
					status_q <= 1'b0;
					state_q  <= S_REPLY;
					if (cmd_q == CMD_INC && !pass_q) begin
						if (deg == '0) begin
							raw_q     <= amt_q;
							created_q <= now_q;
							res_q     <= amt_q;
						end else begin
							state_q <= S_ADDAMT;
						end
					end else begin
						res_q <= deg;
						if (cmd_q == CMD_PEEK && deg == '0) exists_q <= 1'b0;
					end
				end
				S_ADDAMT: begin
					raw_q   <= clamp_full;
					pass_q  <= 1'b1;
					state_q <= S_APPLY;
				end
				S_REPLY: begin
					if (slot_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < div_q))
		else $error("divider remainder not below divisor");

	a_acc_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL || state_q == S_APPLY) |-> (acc_q <= DEG_LIMIT))
		else $error("decay magnitude above saturation limit");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (state_q == S_IDLE))
		else $error("sequencer did not return to idle after reply");

	a_accept_disp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && req_valid) |=> (state_q == S_DISP))
		else $error("accepted beat not dispatched");
endmodule

// ----- rtl/decaying_counter.sv -----
// Top level of the decaying counter: configuration, sequencer and result register.
//
//  channel | handshake             | beat
//  --------+-----------------------+---------------------------------
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//  req     | req_valid / req_stall | req (cmd, amount, now_ms)
//  rsp     | rsp_valid / rsp_stall | rsp (status, result_value)
//
//  A beat for an absent counter or an unused code goes straight to the reply; when the
//  decayed value is needed, a serial divider and a saturating multiplier each take
//  TIME_WIDTH steps of the shared add/subtract unit; a decrement first takes a subtract
//  step, an increment that adds takes an add step; unit code 3 skips both loops.
//  req_stall is high from acceptance until the result is loaded; a reply waits in the
//  sequencer while rsp is held by rsp_stall. Reset clears the counter; cfg always ready.
module decaying_counter #(
	parameter int TIME_WIDTH = 48,
	parameter int FRAC_BITS  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dcnt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dcnt_pkg::VAL_W-1:0]     cfg_data,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  dcnt_pkg::req_t                 req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output dcnt_pkg::rsp_t                 rsp
);
	import dcnt_pkg::*;

	cfg_t regs;
	rsp_t rsp_d, rsp_q;
	logic rsp_valid_q;
	logic slot_free;
	logic done;

	dcnt_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	dcnt_core #(.TIME_WIDTH(TIME_WIDTH)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.regs      (regs),
		.slot_free (slot_free),
		.done      (done),
		.rsp_d     (rsp_d)
	);

	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_q <= rsp_d;
		end
	end
endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the decaying counter: directed table, then randomized settings.
module tb;
	import dcnt_pkg::*;

	typedef longint unsigned u64_t;

	typedef struct packed {
		req_t beat;
		logic typed;
		rsp_t want;
	} row_t;

	localparam logic [CMD_W-1:0]     CMD_SPARE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	localparam longint Q_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint Q_MIN   = -64'sh0000_8000_0000_0000;
	localparam u64_t   SAT_MAG = 64'h0001_0000_0000_0000;
	localparam u64_t   MASK48  = 64'h0000_FFFF_FFFF_FFFF;

	localparam logic [VAL_W-1:0] ONE_Q = 48'd65536;
	localparam logic [VAL_W-1:0] T_END = {VAL_W{1'b1}};

	localparam int HOLD_CYCLES       = 400;
	localparam int WATCHDOG_LIMIT    = 3000;
	localparam int DRAIN_CYCLES      = 120;
	localparam int N_SETTINGS        = 8;
	localparam int ITEMS_PER_SETTING = 85;

	localparam longint PH_RATE [N_SETTINGS] = '{
		65536, 32768, Q_MAX, Q_MIN, 0, 1, -196608, 131072
	};
	localparam int unsigned PH_COUNT [N_SETTINGS] = '{1, 3, 65535, 1, 0, 2, 7, 1};
	localparam logic [UNIT_W-1:0] PH_UNIT [N_SETTINGS] = '{
		UNIT_MS, UNIT_MS, UNIT_MIN, UNIT_SEC, UNIT_MS, UNIT_BAD, UNIT_SEC, UNIT_MS
	};

	// default settings: 1.0 per millisecond
	localparam row_t DIRECTED [25] = '{
		'{'{CMD_PEEK,  48'd0,         48'd0},   1'b1, '{1'b1, 48'd0}},
		'{'{CMD_DEC,   ONE_Q,         48'd0},   1'b1, '{1'b1, 48'd0}},
		'{'{CMD_SPARE, 48'd0,         48'd0},   1'b1, '{1'b1, 48'd0}},
		'{'{CMD_INC,   48'd655360,    48'd100}, 1'b1, '{1'b0, 48'd655360}},
		'{'{CMD_PEEK,  48'd0,         48'd102}, 1'b1, '{1'b0, 48'd524288}},
		'{'{CMD_INC,   ONE_Q,         48'd103}, 1'b0, '{1'b0, 48'd0}},
		'{'{CMD_DEC,   48'd131072,    48'd104}, 1'b0, '{1'b0, 48'd0}},
		'{'{CMD_PEEK,  48'd0,         48'd50},  1'b0, '{1'b0, 48'd0}},
		'{'{CMD_PEEK,  48'd0,         48'd200}, 1'b1, '{1'b0, 48'd0}},
		'{'{CMD_PEEK,  48'd0,         48'd201}, 1'b1, '{1'b1, 48'd0}},
		'{'{CMD_INC,   VAL_MAX,       48'd300}, 1'b1, '{1'b0, VAL_MAX}},
		'{'{CMD_INC,   VAL_MAX,       48'd300}, 1'b1, '{1'b0, VAL_MAX}},
		'{'{CMD_DEC,   VAL_MIN,       48'd300}, 1'b1, '{1'b0, VAL_MAX}},
		'{'{CMD_DEC,   VAL_MAX,       48'd300}, 1'b1, '{1'b0, 48'd0}},
		'{'{CMD_INC,   -48'sd327680,  48'd400}, 1'b1, '{1'b0, -48'sd327680}},
		'{'{CMD_INC,   48'd196608,    48'd400}, 1'b0, '{1'b0, 48'd0}},
		'{'{CMD_INC,   48'd0,         48'd400}, 1'b0, '{1'b0, 48'd0}},
		'{'{CMD_DEC,   -48'sd131072,  48'd401}, 1'b0, '{1'b0, 48'd0}},
		'{'{CMD_PEEK,  48'd0,         T_END},   1'b1, '{1'b0, 48'd0}},
		'{'{CMD_INC,   VAL_MIN,       T_END},   1'b1, '{1'b0, VAL_MIN}},
		'{'{CMD_INC,   VAL_MIN,       T_END},   1'b1, '{1'b0, VAL_MIN}},
		'{'{CMD_DEC,   48'd0,         T_END},   1'b1, '{1'b0, 48'd0}},
		'{'{CMD_INC,   48'd1,         48'd0},   1'b1, '{1'b0, 48'd1}},
		'{'{CMD_PEEK,  48'd0,         48'd0},   1'b1, '{1'b0, 48'd1}},
		'{'{CMD_DEC,   48'd1,         48'd0},   1'b1, '{1'b0, 48'd0}}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [VAL_W-1:0]     cfg_data;
	logic                 req_valid;
	logic                 req_stall;
	req_t                 req_beat;
	logic                 rsp_valid;
	logic                 rsp_stall;
	rsp_t                 rsp_beat;

	// counter and register shadow
	bit                cnt_live;
	longint            cnt_raw;
	u64_t              cnt_born;
	longint            cfg_rate;
	u64_t              cfg_count;
	logic [UNIT_W-1:0] cfg_unit;

	rsp_t replies_due [$];
	int   mismatch_count = 0;
	int   idle_cycles = 0;
	bit   calm;
	bit   stall_hold_req;
	u64_t clock_ms;
	u64_t interval_ms;
	u64_t amount_step;

	decaying_counter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req_beat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp_beat)
	);

	always #1 clk = ~clk;

	function automatic longint clamp_q(longint v, longint lo);
		if (v < lo)
			return lo;
		if (v > Q_MAX)
			return Q_MAX;
		return v;
	endfunction

	function automatic longint decayed_value(u64_t now);
		u64_t   unit_len;
		u64_t   per;
		u64_t   age;
		u64_t   ticks;
		u64_t   step;
		u64_t   mag;
		longint d;
		case (cfg_unit)
			UNIT_MS: unit_len = 1;
			UNIT_SEC: unit_len = 1000;
			UNIT_MIN: unit_len = 60000;
			default: return 0;
		endcase
		per = (cfg_count == 0) ? 1 : cfg_count;
		age = (now >= cnt_born) ? now - cnt_born : 0;
		ticks = age / unit_len / per;
		step = (cfg_rate < 0) ? u64_t'(-cfg_rate) : u64_t'(cfg_rate);
		if (ticks == 0 || step == 0)
			mag = 0;
		else if (ticks > SAT_MAG / step)
			mag = SAT_MAG;
		else
			mag = ticks * step;
		d = (cfg_rate < 0) ? cnt_raw + longint'(mag) : cnt_raw - longint'(mag);
		return clamp_q(d, 0);
	endfunction

	function automatic rsp_t predict_reply(req_t beat);
		longint amt;
		longint res;
		longint v;
		u64_t   now;
		rsp_t   out;
		amt = longint'(beat.amount);
		now = u64_t'(beat.now_ms);
		res = 0;
		out.status = 1'b0;
		case (beat.cmd)
			CMD_INC: begin
				if (!cnt_live || decayed_value(now) == 0) begin
					cnt_live = 1'b1;
					cnt_raw = amt;
					cnt_born = now;
					res = amt;
				end else begin
					cnt_raw = clamp_q(cnt_raw + amt, Q_MIN);
					res = decayed_value(now);
				end
			end
			CMD_DEC: begin
				if (!cnt_live) begin
					out.status = 1'b1;
				end else begin
					v = clamp_q(cnt_raw - amt, 0);
					if (v == 0) begin
						cnt_live = 1'b0;
					end else begin
						cnt_raw = v;
						res = decayed_value(now);
					end
				end
			end
			CMD_PEEK: begin
				if (!cnt_live) begin
					out.status = 1'b1;
				end else begin
					res = decayed_value(now);
					if (res == 0)
						cnt_live = 1'b0;
				end
			end
			default: out.status = 1'b1;
		endcase
		out.result_value = res[VAL_W-1:0];
		return out;
	endfunction

	function automatic logic [VAL_W-1:0] rand_word48();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[VAL_W-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] rand_amount();
		int unsigned      pick;
		logic [VAL_W-1:0] v;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			v = rand_word48();
		end else if (pick < 11) begin
			v = VAL_MAX;
		end else if (pick < 14) begin
			v = VAL_MIN;
		end else if (pick < 20) begin
			v = VAL_W'($urandom_range(0, 3));
		end else begin
			v = VAL_W'(u64_t'($urandom_range(0, 8)) * amount_step +
				u64_t'($urandom_range(0, 65535)));
			if (pick < 30)
				v = -v;
		end
		return v;
	endfunction

	// mostly forward steps around one interval; some repeats, rewinds and jumps
	function automatic logic [VAL_W-1:0] next_time();
		int unsigned pick;
		u64_t        back;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			return clock_ms[VAL_W-1:0];
		if (pick < 15) begin
			back = u64_t'($urandom_range(1, 32'(interval_ms)));
			return VAL_W'((clock_ms > back) ? clock_ms - back : u64_t'(0));
		end
		if (pick < 18)
			clock_ms = u64_t'(rand_word48());
		else if (pick < 21)
			clock_ms += u64_t'($urandom()) * 1000;
		else if (pick < 75)
			clock_ms += u64_t'($urandom_range(0, 32'(interval_ms)));
		else
			clock_ms += u64_t'($urandom_range(1, 4)) * interval_ms;
		clock_ms &= MASK48;
		return clock_ms[VAL_W-1:0];
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_RATE: cfg_rate = longint'($signed(data));
			REG_COUNT: cfg_count = u64_t'(data[COUNT_W-1:0]);
			REG_UNIT: cfg_unit = data[UNIT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(input longint rate, input int unsigned count,
			input logic [UNIT_W-1:0] unit);
		logic [VAL_W-1:0] data;
		u64_t             unit_len;
		u64_t             mag;
		write_reg(REG_RATE, rate[VAL_W-1:0]);
		data = rand_word48();
		data[COUNT_W-1:0] = count[COUNT_W-1:0];
		write_reg(REG_COUNT, data);
		data = rand_word48();
		data[UNIT_W-1:0] = unit;
		write_reg(REG_UNIT, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (unit)
			UNIT_SEC: unit_len = 1000;
			UNIT_MIN: unit_len = 60000;
			UNIT_BAD: unit_len = 1000;
			default: unit_len = 1;
		endcase
		interval_ms = unit_len * u64_t'((count == 0) ? 1 : count);
		mag = (rate < 0) ? u64_t'(-rate) : u64_t'(rate);
		amount_step = (mag == 0 || mag > (64'd1 << 40)) ? 65536 : mag;
	endtask

	task automatic send_beat(input req_t beat, input bit typed, input rsp_t want);
		rsp_t due;
		req_beat <= beat;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		due = predict_reply(beat);
		replies_due.push_back(typed ? want : due);
		if (!calm && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	task automatic drain_replies();
		req_valid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		rsp_stall = 1'b0;
		wait (arst_n);
		forever begin
			if (stall_hold_req) begin
				stall_hold_req = 1'b0;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				rsp_stall <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_reply
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (replies_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected reply: status %0d value %0d",
						rsp_beat.status, rsp_beat.result_value);
			end else begin
				want = replies_due.pop_front();
				if (rsp_beat.status !== want.status ||
						rsp_beat.result_value !== want.result_value) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected %0d/%0d, got %0d/%0d",
							want.status, want.result_value,
							rsp_beat.status, rsp_beat.result_value);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("decaying_counter test failed");
			$finish;
		end
	end

	initial begin
		req_t        beat;
		int unsigned pick;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_valid = 1'b0;
		req_beat = '0;
		cnt_live = 1'b0;
		cnt_raw = 0;
		cnt_born = 0;
		cfg_rate = 65536;
		cfg_count = 1;
		cfg_unit = UNIT_MS;
		clock_ms = 0;
		interval_ms = 1;
		amount_step = 65536;
		calm = 1'b0;
		stall_hold_req = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			send_beat(DIRECTED[i].beat, DIRECTED[i].typed, DIRECTED[i].want);

		for (int p = 0; p < N_SETTINGS; p++) begin
			drain_replies();
			if (PH_UNIT[p] == UNIT_BAD)
				write_reg(REG_SPARE, rand_word48());
			apply_setting(PH_RATE[p], PH_COUNT[p], PH_UNIT[p]);
			for (int k = 0; k < ITEMS_PER_SETTING; k++) begin
				if (p == 1 && k == 10)
					stall_hold_req = 1'b1;
				if (p == 4 && k == 40)
					drain_replies();
				if (p == N_SETTINGS - 1 && k == 25)
					calm = 1'b1;
				pick = $urandom_range(0, 19);
				if (pick < 8)
					beat.cmd = CMD_INC;
				else if (pick < 12)
					beat.cmd = CMD_DEC;
				else if (pick < 19)
					beat.cmd = CMD_PEEK;
				else
					beat.cmd = CMD_SPARE;
				beat.amount = rand_amount();
				beat.now_ms = next_time();
				send_beat(beat, 1'b0, '0);
			end
		end

		drain_replies();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("decaying_counter test passed");
		end else begin
			$display("decaying_counter test failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/dcnt_pkg.sv
rtl/dcnt_alu.sv
rtl/dcnt_cfg.sv
rtl/dcnt_core.sv
rtl/decaying_counter.sv
tb/tb.sv
